// ===== hdl/fiat_shamir_round_verifier_unit_defines.svh =====
// Assertion macros for the round verifier.
// Included by the top level; no other dependencies.
`ifndef FIAT_SHAMIR_ROUND_VERIFIER_UNIT_DEFINES_SVH
`define FIAT_SHAMIR_ROUND_VERIFIER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FSV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FSV_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FSV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/fsv_pkg.sv =====
// Shared types and constants for the round verifier.
// No dependencies.
`default_nettype none
package fsv_pkg;
  localparam int unsigned CNT_W = 16;
  // Configuration register indexes.
  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_PUBKEY  = 2'd1;
  localparam logic [1:0] REG_ROUNDS  = 2'd2;
  // Control handed along the cell row.
  typedef struct packed {
    logic start;   // load operands this cycle
    logic dbl;     // doubling step
    logic add;     // add the multiplicand
  } fsv_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/fsv_if.sv =====
// Valid/ready channel interface carrying a packed payload.
// No dependencies.
`default_nettype none
interface fsv_if #(parameter int unsigned W = 8) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/fsv_cell.sv =====
// One cell of the modular reduction/multiply row: a conditional add mod m.
// Uses fsv_pkg.
`default_nettype none
module fsv_cell import fsv_pkg::*; #(
  parameter int unsigned W = 60
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic [W-1:0] m,
  input  wire logic         do_add,
  output logic [W-1:0]      q_r
);
  logic [W:0]   sum;
  logic [W-1:0] q_nxt;
  // a, b < m, so one compare and subtract reduces the sum.
  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    if (!do_add) q_nxt = a;
    else if (sum >= {1'b0, m}) q_nxt = W'(sum - {1'b0, m});
    else q_nxt = sum[W-1:0];
  end
  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end
endmodule
`default_nettype wire

// ===== hdl/fsv_mulmod.sv =====
// Bit-serial modular multiplier: double-then-add cells in a row, one multiplier bit at a time.
// Uses fsv_pkg and fsv_cell.
`default_nettype none
module fsv_mulmod import fsv_pkg::*; #(
  parameter int unsigned W = 60
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic [W-1:0] m,
  output logic              busy_r,
  output logic [W-1:0]      prod
);
  localparam int unsigned IW = $clog2(W + 1);
  logic [IW-1:0] cnt_r;
  logic [W-1:0]  b_r, a_r;
  logic [W-1:0]  dbl_q, acc_q;
  fsv_ctl_t      ctl;
  // Cell 0 doubles the accumulator, cell 1 adds a when the bit is set;
  // the two alternate, one step each for every multiplier bit.
  logic phase_r;
  assign ctl.start = start;
  assign ctl.dbl   = busy_r && !phase_r;
  assign ctl.add   = busy_r && phase_r;
  fsv_cell #(.W(W)) u_dbl (
    .clk(clk), .en(ctl.start || ctl.dbl),
    .a(ctl.start ? '0 : acc_q), .b(ctl.start ? '0 : acc_q), .m(m),
    .do_add(!ctl.start), .q_r(dbl_q));
  fsv_cell #(.W(W)) u_add (
    .clk(clk), .en(ctl.start || ctl.add),
    .a(ctl.start ? '0 : dbl_q), .b(a_r), .m(m),
    .do_add(!ctl.start && b_r[W-1]), .q_r(acc_q));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else if (start) begin
      busy_r  <= 1'b1;
      phase_r <= 1'b0;
      cnt_r   <= IW'(W);
    end else if (busy_r) begin
      phase_r <= !phase_r;
      if (phase_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == IW'(1)) busy_r <= 1'b0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (ctl.add) begin
      b_r <= {b_r[W-2:0], 1'b0};
    end
  end
  assign prod = acc_q;
endmodule
`default_nettype wire

// ===== hdl/fiat_shamir_round_verifier_unit.sv =====
// Top level of the round verifier: control sequencer, registers and output stage.
// Uses fsv_pkg, fsv_if, fsv_mulmod and the assertion macro header.
`default_nettype none
`include "fiat_shamir_round_verifier_unit_defines.svh"
// This block checks one round of identification at a time. Each input item carries
// a commitment x, a challenge bit e and a response y; the result item reports whether
// y*y mod N equals x*v^e mod N with y nonzero and N at least 2, the zero-based
// round index, and whether the session ends here with its verdict. Operands x, y
// and v are first reduced modulo N in turn by a bit-serial restoring pass, then
// one or two multiplications (y*y, and x*v when e is set) run through a shared
// double-and-add cell row. One item is in flight at a time: the input stays closed
// while a result waits, and the next item can be accepted at the edge after the
// result has been taken. Configuration is to be written only between items; the
// block itself does not enforce this, so the user is bound to it. It takes effect
// with the next round.
module fiat_shamir_round_verifier_unit import fsv_pkg::*; #(
  parameter int unsigned MOD_BITS = 60
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [59:0] cfg_wdata,
  fsv_if.sink              in_ch,
  fsv_if.source            out_ch
);
  localparam int unsigned W  = MOD_BITS;
  localparam int unsigned IW = $clog2(W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RX, S_RY, S_RV, S_MUL_Y, S_WAIT_Y, S_MUL_X, S_WAIT_X, S_DONE
  } state_t;

  state_t          state_r;
  logic [59:0]     mod_r, key_r;
  logic [15:0]     rounds_r, count_r;
  logic [W-1:0]    m;
  logic [W-1:0]    x_r, y_r, v_r, lhs_r;
  logic            e_r;
  // Serial reduction: remainder and shifting source.
  logic [W:0]      rem_r;
  logic [W-1:0]    src_r;
  logic [IW-1:0]   bit_r;
  logic [W:0]      rem_sh;
  logic            mul_start, mul_busy;
  logic [W-1:0]    mul_a, mul_b, mul_p;
  logic            out_valid_r, ok;
  logic [18:0]     out_data_r;
  logic [15:0]     need;
  logic            last;

  assign m = W'(mod_r);
  assign rem_sh = {rem_r[W-1:0], src_r[W-1]};

  fsv_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b), .m(m),
    .busy_r(mul_busy), .prod(mul_p));

  assign mul_start = (state_r == S_MUL_Y) || (state_r == S_MUL_X);
  assign mul_a = (state_r == S_MUL_Y) ? y_r : x_r;
  assign mul_b = (state_r == S_MUL_Y) ? y_r : v_r;

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign need = (rounds_r == 16'd0) ? 16'd1 : rounds_r;
  assign ok = (m >= W'(2)) && (y_r != '0) && (lhs_r == (e_r ? mul_p : x_r));
  assign last = !ok || ({1'b0, count_r} + 17'd1 >= {1'b0, need});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r    <= 60'd3;
      key_r    <= '0;
      rounds_r <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS: mod_r <= cfg_wdata;
        REG_PUBKEY:  key_r <= cfg_wdata;
        REG_ROUNDS:  rounds_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          x_r   <= W'(in_ch.data[120:61]);
          e_r   <= in_ch.data[60];
          y_r   <= W'(in_ch.data[59:0]);
          src_r <= W'(in_ch.data[120:61]);
          rem_r <= '0;
          bit_r <= IW'(W);
          state_r <= S_RX;
        end
        S_RX, S_RY, S_RV: begin
          // One restoring step per cycle; m < 2 leaves junk, masked by ok.
          if (bit_r == IW'(1)) begin
            bit_r <= IW'(W);
            rem_r <= '0;
            if (state_r == S_RX) begin
              x_r   <= (rem_sh >= {1'b0, m}) ? W'(rem_sh - {1'b0, m}) : rem_sh[W-1:0];
              src_r <= y_r;
              state_r <= S_RY;
            end else if (state_r == S_RY) begin
              y_r   <= (rem_sh >= {1'b0, m}) ? W'(rem_sh - {1'b0, m}) : rem_sh[W-1:0];
              src_r <= W'(key_r);
              state_r <= S_RV;
            end else begin
              v_r   <= (rem_sh >= {1'b0, m}) ? W'(rem_sh - {1'b0, m}) : rem_sh[W-1:0];
              state_r <= S_MUL_Y;
            end
          end else begin
            if (rem_sh >= {1'b0, m}) rem_r <= rem_sh - {1'b0, m};
            else rem_r <= rem_sh;
            src_r <= {src_r[W-2:0], 1'b0};
            bit_r <= bit_r - 1'b1;
          end
        end
        S_MUL_Y: state_r <= S_WAIT_Y;
        S_WAIT_Y: if (!mul_busy) begin
          lhs_r   <= mul_p;
          state_r <= e_r ? S_MUL_X : S_DONE;
        end
        S_MUL_X: state_r <= S_WAIT_X;
        S_WAIT_X: if (!mul_busy) state_r <= S_DONE;
        S_DONE: begin
          // The product register still holds x*v here when e is set.
          out_valid_r <= 1'b1;
          out_data_r  <= {ok, last, last && ok, count_r};
          count_r     <= last ? 16'd0 : count_r + 16'd1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `FSV_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ch.ready, state_r == S_IDLE)
  `FSV_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `FSV_ASSERT_IMPL(a_acc_end, clk, rst_n, out_valid_r && out_data_r[16], out_data_r[17])
endmodule
`default_nettype wire

// ===== bench/fiat_shamir_round_verifier_unit_tb.sv =====
// Self-checking testbench for the Fiat-Shamir round verifier.
// Depends on fsv_pkg, fsv_if and fiat_shamir_round_verifier_unit from the RTL.
`default_nettype none

module fiat_shamir_round_verifier_unit_tb import fsv_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OP_W  = 60;
  localparam int unsigned IN_W  = 2 * OP_W + 1;
  localparam int unsigned OUT_W = 3 + CNT_W;

  localparam logic [OP_W-1:0] OP_MAX = {OP_W{1'b1}};

  typedef struct {
    logic             round_ok;
    logic             session_end;
    logic             accepted;
    logic [CNT_W-1:0] round_index;
  } verdict_t;

  // Tracks the verifier's registers and session count, and holds the verdicts
  // still owed by the block in the order their rounds were accepted.
  class round_scoreboard;
    logic [OP_W-1:0]  modulus;
    logic [OP_W-1:0]  pubkey;
    logic [CNT_W-1:0] rounds;
    logic [CNT_W-1:0] passed;
    verdict_t         owed[$];
    int               errors;

    function new();
      modulus = OP_W'(3);
      pubkey  = '0;
      rounds  = CNT_W'(1);
      passed  = '0;
      errors  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [OP_W-1:0] val);
      case (idx)
        REG_MODULUS: modulus = val;
        REG_PUBKEY:  pubkey  = val;
        REG_ROUNDS:  rounds  = val[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [OP_W-1:0] mulmod(logic [OP_W-1:0] a, logic [OP_W-1:0] b,
                                     logic [OP_W-1:0] m);
      logic [2*OP_W-1:0] prod;
      prod = a * b;
      return OP_W'(prod % m);
    endfunction

    // Works out the verdict of one accepted round and advances the session.
    function void note_round(logic [OP_W-1:0] x, logic e, logic [OP_W-1:0] y);
      verdict_t        v;
      logic [OP_W-1:0] xr, yr, kr, rhs;
      logic [CNT_W:0]  need;
      v.round_ok = 1'b0;
      if (modulus >= 2) begin
        xr  = x % modulus;
        yr  = y % modulus;
        kr  = pubkey % modulus;
        rhs = e ? mulmod(xr, kr, modulus) : xr;
        v.round_ok = (yr != 0) && (mulmod(yr, yr, modulus) == rhs);
      end
      need          = (rounds == 0) ? (CNT_W + 1)'(1) : {1'b0, rounds};
      v.round_index = passed;
      v.session_end = !v.round_ok || ({1'b0, passed} + 1 >= need);
      v.accepted    = v.session_end && v.round_ok;
      passed        = v.session_end ? '0 : passed + 1'b1;
      owed.insert(owed.size(), v);
    endfunction

    function void report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      verdict_t v;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      v = owed.pop_front();
      if (d[18] !== v.round_ok)
        report($sformatf("round_ok %b, expected %b", d[18], v.round_ok));
      if (d[17] !== v.session_end)
        report($sformatf("session_end %b, expected %b", d[17], v.session_end));
      if (d[16] !== v.accepted)
        report($sformatf("accepted %b, expected %b", d[16], v.accepted));
      if (d[15:0] !== v.round_index)
        report($sformatf("round_index %0d, expected %0d", d[15:0], v.round_index));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [OP_W-1:0]   cfg_wdata;

  fsv_if #(.W(IN_W))  in_ch (clk);
  fsv_if #(.W(OUT_W)) out_ch (clk);

  fiat_shamir_round_verifier_unit #(.MOD_BITS(OP_W)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  round_scoreboard sb = new();

  // Idle percentages for the two sides, changed per phase by the main process.
  int send_idle_pct;
  int recv_idle_pct;
  // A long receiver hold-off is requested by setting hold_go; the receiver
  // process takes the request and counts the stall down itself.
  bit hold_go;
  int hold_left;

  // Key material of the current setting: v = s*s mod N.
  logic [OP_W-1:0] secret;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_MODULUS;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random back-pressure, plus the one long stall.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result that the block hands over is checked against the oldest verdict owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.data);
  end

  function automatic logic [OP_W-1:0] rand_op();
    return OP_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [OP_W-1:0] rand_below(logic [OP_W-1:0] m);
    return (m == 0) ? rand_op() : rand_op() % m;
  endfunction

  // Offers one round and returns once the block has taken it.
  task automatic send_round(logic [OP_W-1:0] x, logic e, logic [OP_W-1:0] y);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {x, e, y};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_round(x, e, y);
  endtask

  // Waits until the block owes nothing more, with a little margin after.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [OP_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Programs a modulus and a fresh key pair v = s*s mod N.
  task automatic set_key(logic [OP_W-1:0] n);
    secret = rand_below(n);
    write_reg(REG_MODULUS, n);
    write_reg(REG_PUBKEY, (n < 2) ? rand_op() : sb.mulmod(secret, secret, n));
  endtask

  // One honest round with random content; a minority are spoiled in various
  // ways so that sessions also end early. Operands sometimes carry an extra N.
  task automatic honest_round();
    logic [OP_W-1:0] n, r, x, y;
    logic            e;
    int              kind;
    n    = sb.modulus;
    r    = (n < 2) ? rand_op() : rand_below(n);
    e    = 1'($urandom_range(1));
    x    = (n < 2) ? rand_op() : sb.mulmod(r, r, n);
    y    = (n < 2 || !e) ? r : sb.mulmod(r, secret, n);
    kind = $urandom_range(99);
    if (kind < 5)
      y = '0;
    else if (kind < 10)
      y = y ^ (OP_W'(1) << $urandom_range(OP_W - 1));
    else if (kind < 14)
      x = rand_op();
    else if (kind < 20 && n >= 2 && y <= OP_MAX - n)
      y = y + n;
    else if (kind < 26 && n >= 2 && x <= OP_MAX - n)
      x = x + n;
    if ($urandom_range(99) < 3) begin
      x = rand_op();
      y = rand_op();
    end
    send_round(x, e, y);
  endtask

  task automatic random_phase(int sender_pct, int receiver_pct, bit with_hold);
    logic [OP_W-1:0] n;
    int              sel;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int set = 0; set < 6; set++) begin
      drain();
      sel = $urandom_range(9);
      if (set == 0)
        n = OP_MAX;
      else if (sel < 3)
        n = OP_W'($urandom_range(1000, 3));
      else if (sel == 3)
        n = OP_W'($urandom_range(1));
      else
        n = rand_op() | (OP_W'(1) << (OP_W - 1));
      set_key(n);
      write_reg(REG_ROUNDS, OP_W'($urandom_range(8)));
      if (with_hold && set == 2)
        hold_go = 1'b1;
      for (int k = 0; k < 28; k++) begin
        honest_round();
        // Shrink or grow the session length mid-session now and then.
        if (k == 13 && $urandom_range(1)) begin
          drain();
          write_reg(REG_ROUNDS, OP_W'($urandom_range(3)));
        end
      end
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go       = 1'b0;
    hold_left     = 0;
    secret        = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset setting: N = 3, v = 0, one round per session.
    send_round('0, 1'b0, '0);
    send_round(OP_W'(1), 1'b0, OP_W'(1));
    send_round(OP_W'(1), 1'b0, OP_W'(4));
    send_round('0, 1'b1, OP_W'(3));
    send_round(OP_MAX, 1'b1, OP_MAX);
    send_round(OP_MAX, 1'b0, OP_MAX);

    // A modulus of zero or one makes every round fail.
    drain();
    write_reg(REG_MODULUS, '0);
    send_round(OP_W'(1), 1'b0, OP_W'(1));
    send_round(OP_MAX, 1'b1, OP_MAX);
    drain();
    write_reg(REG_MODULUS, OP_W'(1));
    send_round('0, 1'b0, OP_W'(1));
    send_round(OP_MAX, 1'b1, '0);

    // The largest modulus, rounds of zero acting as one, then longer sessions.
    drain();
    set_key(OP_MAX);
    write_reg(REG_ROUNDS, '0);
    honest_round();
    honest_round();
    drain();
    write_reg(REG_ROUNDS, OP_W'(16'hFFFF));
    send_round(OP_W'(1), 1'b0, OP_W'(1));
    send_round(OP_W'(1), 1'b0, OP_MAX);
    send_round(OP_W'(1), 1'b0, OP_W'(1));
    // Dropping the session length to no more than the rounds passed ends the next round.
    drain();
    write_reg(REG_ROUNDS, OP_W'(1));
    send_round(OP_W'(1), 1'b0, OP_W'(1));
    drain();
    write_reg(REG_ROUNDS, OP_W'(3));
    send_round(OP_W'(4), 1'b0, OP_W'(2));
    send_round(OP_W'(4), 1'b0, OP_W'(2));
    send_round(OP_W'(4), 1'b0, OP_W'(2));

    random_phase(12, 47, 1'b0);
    random_phase(47, 12, 1'b0);
    random_phase(0, 0, 1'b1);

    drain();
    if (sb.errors == 0) begin
      $display("fiat_shamir_round_verifier_unit_tb OK");
    end else begin
      $display("fiat_shamir_round_verifier_unit_tb NOT OK");
    end
    $finish;
  end

  // Safety net: about 520 items plus stalls fit well inside this bound.
  initial begin
    #40_000_000;
    $display("fiat_shamir_round_verifier_unit_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/fsv_pkg.sv
hdl/fsv_if.sv
hdl/fsv_cell.sv
hdl/fsv_mulmod.sv
hdl/fiat_shamir_round_verifier_unit.sv
bench/fiat_shamir_round_verifier_unit_tb.sv
